// ===== rtl/core/mhbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mail header block scanner package
// Shared types, character codes and header name tables for the scanner.
// ----------------------------------------------------------------------------
package mhbs_pkg;

	localparam int NUM_NAMES = 4;
	localparam int NAME_SLOTS = 16;

	// Header name indexes
	localparam int NAME_RECEIVED = 0;
	localparam int NAME_DATE = 1;
	localparam int NAME_MSG_ID = 2;
	localparam int NAME_FROM = 3;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [7:0] HOP_MAX = 8'hFF;
	localparam logic [3:0] POS_MAX = 4'd15;

	// Lowercase header names, padded with zero bytes
	localparam logic [7:0] NAME_TEXT [NUM_NAMES][NAME_SLOTS] = '{
		'{"r", "e", "c", "e", "i", "v", "e", "d", ":",
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "a", "t", "e", ":",
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"m", "e", "s", "s", "a", "g", "e", "-", "i", "d", ":",
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "r", "o", "m", ":",
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{4'd9, 4'd5, 4'd11, 4'd5};

	typedef enum logic [1:0] {
		MODE_LINE_START = 2'd0,
		MODE_IN_NAME    = 2'd1,
		MODE_SKIP_LINE  = 2'd2,
		MODE_DONE       = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		logic             cont_ok;
		logic [3:0]       name_pos;
		logic [NUM_NAMES-1:0] alive;
		logic             header_seen;
		logic [7:0]       rcv_count;
		logic [2:0]       found;
	} scan_state_t;

	localparam scan_state_t STATE_RESET = '{
		mode: MODE_LINE_START,
		cont_ok: 1'b0,
		name_pos: 4'd0,
		alive: '0,
		header_seen: 1'b0,
		rcv_count: 8'd0,
		found: 3'd0
	};

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic       headers_present;
		logic [7:0] hop_count;
		logic       saw_date;
		logic       saw_message_id;
		logic       saw_from;
	} out_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/mhbs_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mail header block scanner step
// Next-state logic for one byte: line mode and header name matching.
// ----------------------------------------------------------------------------
module mhbs_step (
	input  wire mhbs_pkg::scan_state_t cur,
	input  wire logic [7:0]            text_byte,
	output mhbs_pkg::scan_state_t      nxt
);

	logic                              is_alnum;
	logic [7:0]                        folded;
	mhbs_pkg::scan_state_t             base;
	mhbs_pkg::scan_state_t             matched;
	logic                              do_match;

	always_comb begin
		is_alnum = (text_byte >= "0" && text_byte <= "9") ||
			(text_byte >= "A" && text_byte <= "Z") ||
			(text_byte >= "a" && text_byte <= "z");
		folded = (text_byte >= "A" && text_byte <= "Z") ? (text_byte + 8'h20) : text_byte;
	end

	// Mode update; base carries the name reset at the start of a header name
	always_comb begin
		base = cur;
		do_match = 1'b0;
		unique case (cur.mode)
			mhbs_pkg::MODE_LINE_START: begin
				if (text_byte == mhbs_pkg::CH_SPACE || text_byte == mhbs_pkg::CH_TAB) begin
					base.mode = cur.cont_ok ? mhbs_pkg::MODE_SKIP_LINE : mhbs_pkg::MODE_DONE;
				end else if (is_alnum) begin
					base.cont_ok = 1'b1;
					base.name_pos = 4'd0;
					base.alive = '1;
					base.mode = mhbs_pkg::MODE_IN_NAME;
					do_match = 1'b1;
				end else if (text_byte == mhbs_pkg::CH_LF) begin
					base.mode = mhbs_pkg::MODE_DONE;
				end
			end
			mhbs_pkg::MODE_IN_NAME: begin
				if (text_byte == mhbs_pkg::CH_LF) begin
					base.mode = mhbs_pkg::MODE_DONE;
				end else begin
					do_match = 1'b1;
					if (text_byte == mhbs_pkg::CH_COLON) begin
						base.header_seen = 1'b1;
						base.mode = mhbs_pkg::MODE_SKIP_LINE;
					end
				end
			end
			mhbs_pkg::MODE_SKIP_LINE: begin
				if (text_byte == mhbs_pkg::CH_LF) begin
					base.mode = mhbs_pkg::MODE_LINE_START;
				end
			end
			mhbs_pkg::MODE_DONE: begin
				base = cur;
			end
			default: begin
				base = cur;
			end
		endcase
	end

	// Compare the folded byte against every live name at the current position
	always_comb begin
		matched = base;
		for (int k = 0; k < mhbs_pkg::NUM_NAMES; k++) begin
			if (base.alive[k]) begin
				if (base.name_pos >= mhbs_pkg::NAME_LEN[k] ||
					mhbs_pkg::NAME_TEXT[k][base.name_pos] != folded) begin
					matched.alive[k] = 1'b0;
				end else if (base.name_pos + 4'd1 == mhbs_pkg::NAME_LEN[k]) begin
					if (k == mhbs_pkg::NAME_RECEIVED) begin
						if (base.rcv_count != mhbs_pkg::HOP_MAX) begin
							matched.rcv_count = base.rcv_count + 8'd1;
						end
					end else if (k == mhbs_pkg::NAME_DATE) begin
						matched.found[0] = 1'b1;
					end else if (k == mhbs_pkg::NAME_MSG_ID) begin
						matched.found[1] = 1'b1;
					end else if (k == mhbs_pkg::NAME_FROM) begin
						matched.found[2] = 1'b1;
					end
				end
			end
		end
		if (base.name_pos != mhbs_pkg::POS_MAX) begin
			matched.name_pos = base.name_pos + 4'd1;
		end
		nxt = do_match ? matched : base;
	end

endmodule
`default_nettype wire

// ===== rtl/core/mail_header_block_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A word marked last passes the input stage, then sets result_valid in the result register.
// Throughput: one input word per cycle while byte_stall is low; the scan state updates per retired word.
// Only a full, stalled result register holds back a last word in the input stage.
// Reset: arst_n clears the scan state and the valid bits of both registers.
// The scan state also returns to its reset value after each last word.
// ----------------------------------------------------------------------------
// Mail header block scanner
// Classifies the head of a message byte by byte, counts Received hops and
// flags Date, Message-ID and From headers; reports once per message.
// ----------------------------------------------------------------------------
module mail_header_block_scanner (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	input  wire  logic                 byte_valid,
	output logic                       byte_stall,
	input  wire  mhbs_pkg::in_word_t   byte_word,
	output logic                       result_valid,
	input  wire  logic                 result_stall,
	output mhbs_pkg::out_word_t        result_word
);

	// Input stage
	logic                  valid_s1;
	mhbs_pkg::in_word_t    word_s1;

	// Scan state and result register
	mhbs_pkg::scan_state_t state_q;
	mhbs_pkg::scan_state_t state_nxt;
	logic                  result_valid_q;
	mhbs_pkg::out_word_t   result_word_q;

	logic                  out_free;
	logic                  fire_s1;
	logic                  load_s1;

	// The result register frees up when empty or when its word is taken.
	assign out_free = !result_valid_q || !result_stall;
	// Retire the staged word; a last word also needs room for its result.
	assign fire_s1 = valid_s1 && (!word_s1.is_last || out_free);
	// Hold new input only while the staged word cannot retire.
	assign byte_stall = valid_s1 && !fire_s1;
	assign load_s1 = byte_valid && !byte_stall;

	mhbs_step u_step (
		.cur       (state_q),
		.text_byte (word_s1.text_byte),
		.nxt       (state_nxt)
	);

	// Input stage: control bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage: payload
	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= byte_word;
		end
	end

	// Scan state: advance on each retired word, restart after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhbs_pkg::STATE_RESET;
		end else if (fire_s1) begin
			if (word_s1.is_last) begin
				state_q <= mhbs_pkg::STATE_RESET;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	// Result register: control bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1 && word_s1.is_last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result register: payload, taken from the state after the last byte
	always_ff @(posedge clk) begin
		if (fire_s1 && word_s1.is_last) begin
			result_word_q.headers_present <= state_nxt.header_seen;
			result_word_q.hop_count <= state_nxt.rcv_count;
			result_word_q.saw_date <= state_nxt.found[0];
			result_word_q.saw_message_id <= state_nxt.found[1];
			result_word_q.saw_from <= state_nxt.found[2];
		end
	end

	assign result_valid = result_valid_q;
	assign result_word = result_word_q;

endmodule
`default_nettype wire

// ===== rtl/core/mhbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mail header block scanner checker
// Port-level properties of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
module mhbs_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                byte_valid,
	input wire logic                byte_stall,
	input wire mhbs_pkg::in_word_t  byte_word,
	input wire logic                result_valid,
	input wire logic                result_stall,
	input wire mhbs_pkg::out_word_t result_word
);

	// Hold a stalled result in place
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_word))
		else $error("stalled result dropped or changed");

	// A hop counts only on a name ending in a colon
	a_hop_needs_header: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.hop_count != 8'd0 |-> result_word.headers_present)
		else $error("hop count without header");

	// Each name flag also needs a completed header name
	a_flag_needs_header: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_word.saw_date || result_word.saw_message_id ||
			result_word.saw_from) |-> result_word.headers_present)
		else $error("name flag without header");

	// A fresh result follows an accepted last word
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && !byte_stall && byte_word.is_last, 2))
		else $error("result without last word");

endmodule

bind mail_header_block_scanner mhbs_checker u_mhbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_stall   (byte_stall),
	.byte_word    (byte_word),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_word  (result_word)
);
`default_nettype wire
